// ----- hw/rtl/bgfe_pkg.sv -----
package bgfe_pkg;

	// opcodes of an input transfer
	localparam logic [1:0] OP_DATA   = 2'd0;
	localparam logic [1:0] OP_END    = 2'd1;
	localparam logic [1:0] OP_FILL   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// cell kinds
	localparam logic [1:0] KIND_SYNC = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_FILL = 2'd2;

	// grid geometry
	localparam logic [6:0] FIRST_ROW  = 7'd12;
	localparam logic [6:0] LAST_ROW   = 7'd64;
	localparam logic [6:0] DATA_COL0  = 7'd31;
	localparam logic [6:0] SYNC_COL0  = 7'd24;
	localparam logic [6:0] NARROW_COL0 = 7'd24;
	localparam logic [6:0] WIDE_COL0  = 7'd16;
	localparam logic [6:0] NARROW_END = 7'd60;
	localparam logic [6:0] WIDE_END   = 7'd68;
	localparam logic [6:0] WIDE_ROW0  = 7'd20;
	localparam logic [6:0] WIDE_ROW1  = 7'd56;
	localparam logic [6:0] UPPER_ROW1 = 7'd19;

	localparam logic [2:0] SYNC_LAST  = 3'd6;
	localparam logic [4:0] BYTE_CELLS = 5'd9;
	localparam logic [4:0] TERM_CELLS = 5'd18;

	localparam logic [15:0] LIMIT_RESET = 16'd60002;
	localparam logic [7:0]  FRAME_MAX   = 8'd255;

	// register map (word index taken from paddr[2])
	localparam logic REG_BYTE_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SYNC,
		ST_CELL
	} state_t;

	// result of one position step
	typedef struct packed {
		logic [6:0] next_row;
		logic [6:0] next_col;
		logic       row_done;
		logic       frame_done;
		logic       frame_last;
	} pos_step_t;

endpackage

// ----- hw/rtl/bgfe_pos_step.sv -----
module bgfe_pos_step (
	input  logic [6:0]          row,
	input  logic [6:0]          col,
	output bgfe_pkg::pos_step_t step
);

	logic       wide_row;
	logic [6:0] row_end;
	logic [6:0] row_inc;
	logic [6:0] first_col;

	always_comb begin
		wide_row  = (row >= bgfe_pkg::WIDE_ROW0) && (row <= bgfe_pkg::WIDE_ROW1);
		row_end   = wide_row ? bgfe_pkg::WIDE_END : bgfe_pkg::NARROW_END;
		row_inc   = row + 7'd1;
		if (row_inc <= bgfe_pkg::UPPER_ROW1) begin
			first_col = bgfe_pkg::NARROW_COL0;
		end else if (row_inc <= bgfe_pkg::WIDE_ROW1) begin
			first_col = bgfe_pkg::WIDE_COL0;
		end else begin
			first_col = bgfe_pkg::NARROW_COL0;
		end

		step.row_done   = (col >= row_end);
		step.frame_done = step.row_done && (row >= bgfe_pkg::LAST_ROW);
		step.frame_last = (row == bgfe_pkg::LAST_ROW) && (col == bgfe_pkg::NARROW_END);
		if (step.frame_done) begin
			step.next_row = bgfe_pkg::FIRST_ROW;
			step.next_col = bgfe_pkg::DATA_COL0;
		end else if (step.row_done) begin
			step.next_row = row_inc;
			step.next_col = first_col;
		end else begin
			step.next_row = row;
			step.next_col = col + 7'd1;
		end
	end

endmodule

// ----- hw/rtl/bit_grid_frame_encoder_unit.sv -----
// Bit grid frame encoder.
// Input channel (in_valid/in_ready, opcode, data_byte): one transfer is a data
// byte, an end-of-data mark or a fill request. Output channel (out_valid/
// out_ready): one transfer per grid cell with its frame, row, column, color,
// kind, and the run_last / frame_last flags.
// A data byte yields nine cells (MSB first, then odd parity), end of data
// eighteen black cells, fill the rest of the current row. The first cell of
// a frame is preceded by seven sync cells, after a step that opens the frame.
// A sequencer drives one shared position-step unit, one cell per cycle while
// the output register is free; an item is accepted, then its cells are sent,
// and items with no cells are accepted but leave the sequencer idle.
// in_ready is high only while the sequencer is idle; a cell is held in the
// output register while out_ready is low and the sequencer waits with it.
// The last cell of an item may still wait while the next item is accepted.
// Reset (arst_n low) returns to row 12 col 31 with no frame open, clears the
// byte count and end flag and loads byte_limit with 60002. Register
// byte_limit sits at byte address 0 of the APB port.
module bit_grid_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  data_byte,
	// cells
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_index,
	output logic [6:0]  cell_row,
	output logic [6:0]  cell_col,
	output logic        cell_white,
	output logic [1:0]  cell_kind,
	output logic        run_last,
	output logic        frame_last
);

	bgfe_pkg::state_t state_q, state_d;

	logic [15:0] limit_q;
	logic [7:0]  frame_count_q, frame_count_d;
	logic [6:0]  row_q, row_d;
	logic [6:0]  col_q, col_d;
	logic        open_q, open_d;
	logic [15:0] bytes_q, bytes_d;
	logic        ended_q, ended_d;
	logic        phase_q, phase_d;
	logic [4:0]  cnt_q, cnt_d;       // cells left in a data or terminator run
	logic [8:0]  shift_q, shift_d;   // cell colors, MSB first
	logic        fill_q, fill_d;
	logic [2:0]  sync_q, sync_d;

	logic        out_valid_q, out_valid_d;
	logic [7:0]  o_frame_q;
	logic [6:0]  o_row_q, o_col_q;
	logic        o_white_q;
	logic [1:0]  o_kind_q;
	logic        o_last_q, o_flast_q;

	logic        ld;
	logic [6:0]  ld_col;
	logic        ld_white;
	logic [1:0]  ld_kind;
	logic        ld_last, ld_flast, ld_row_sync;
	logic        adv;
	logic        cell_last;

	bgfe_pkg::pos_step_t step;

	bgfe_pos_step u_step (
		.row  (row_q),
		.col  (col_q),
		.step (step)
	);

	// configuration port
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == bgfe_pkg::REG_BYTE_LIMIT);
	assign prdata = (paddr[2] == bgfe_pkg::REG_BYTE_LIMIT) ? {16'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bgfe_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[15:0];
		end
	end

	// output register frees when empty or being taken
	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = (state_q == bgfe_pkg::ST_IDLE);
	assign cell_last = fill_q ? step.row_done : (cnt_q == 5'd1);

	always_comb begin
		state_d       = state_q;
		frame_count_d = frame_count_q;
		row_d         = row_q;
		col_d         = col_q;
		open_d        = open_q;
		bytes_d       = bytes_q;
		ended_d       = ended_q;
		phase_d       = phase_q;
		cnt_d         = cnt_q;
		shift_d       = shift_q;
		fill_d        = fill_q;
		sync_d        = sync_q;
		ld            = 1'b0;
		ld_row_sync   = 1'b0;
		ld_col        = col_q;
		ld_white      = 1'b0;
		ld_kind       = bgfe_pkg::KIND_DATA;
		ld_last       = 1'b0;
		ld_flast      = 1'b0;

		case (state_q)
			bgfe_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (opcode)
						bgfe_pkg::OP_DATA: begin
							if (!ended_q && (bytes_q < limit_q)) begin
								bytes_d = bytes_q + 16'd1;
								shift_d = {data_byte, ~^data_byte};
								cnt_d   = bgfe_pkg::BYTE_CELLS;
								fill_d  = 1'b0;
								state_d = bgfe_pkg::ST_CELL;
							end
						end
						bgfe_pkg::OP_END: begin
							if (!ended_q) begin
								ended_d = 1'b1;
								shift_d = 9'd0;
								cnt_d   = bgfe_pkg::TERM_CELLS;
								fill_d  = 1'b0;
								state_d = bgfe_pkg::ST_CELL;
							end
						end
						bgfe_pkg::OP_FILL: begin
							if (open_q) begin
								fill_d  = 1'b1;
								state_d = bgfe_pkg::ST_CELL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			bgfe_pkg::ST_SYNC: begin
				if (adv) begin
					ld          = 1'b1;
					ld_row_sync = 1'b1;
					ld_col      = bgfe_pkg::SYNC_COL0 + {4'd0, sync_q};
					ld_white    = phase_q;
					ld_kind     = bgfe_pkg::KIND_SYNC;
					sync_d      = sync_q + 3'd1;
					if (sync_q == bgfe_pkg::SYNC_LAST) begin
						state_d = bgfe_pkg::ST_CELL;
					end
				end
			end
			bgfe_pkg::ST_CELL: begin
				if (!open_q) begin
					// open a new frame, sync cells go first
					open_d  = 1'b1;
					phase_d = ~phase_q;
					sync_d  = 3'd0;
					if (frame_count_q != bgfe_pkg::FRAME_MAX) begin
						frame_count_d = frame_count_q + 8'd1;
					end
					state_d = bgfe_pkg::ST_SYNC;
				end else if (adv) begin
					ld       = 1'b1;
					ld_col   = col_q;
					ld_white = fill_q ? (row_q[0] ^ col_q[0]) : shift_q[8];
					ld_kind  = fill_q ? bgfe_pkg::KIND_FILL : bgfe_pkg::KIND_DATA;
					ld_last  = cell_last;
					ld_flast = step.frame_last;
					row_d    = step.next_row;
					col_d    = step.next_col;
					if (step.frame_done) begin
						open_d = 1'b0;
					end
					shift_d = {shift_q[7:0], 1'b0};
					cnt_d   = cnt_q - 5'd1;
					if (cell_last) begin
						state_d = bgfe_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = bgfe_pkg::ST_IDLE;
			end
		endcase

		out_valid_d = ld ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bgfe_pkg::ST_IDLE;
			frame_count_q <= 8'd0;
			row_q         <= bgfe_pkg::FIRST_ROW;
			col_q         <= bgfe_pkg::DATA_COL0;
			open_q        <= 1'b0;
			bytes_q       <= 16'd0;
			ended_q       <= 1'b0;
			phase_q       <= 1'b0;
			cnt_q         <= 5'd0;
			fill_q        <= 1'b0;
			sync_q        <= 3'd0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			frame_count_q <= frame_count_d;
			row_q         <= row_d;
			col_q         <= col_d;
			open_q        <= open_d;
			bytes_q       <= bytes_d;
			ended_q       <= ended_d;
			phase_q       <= phase_d;
			cnt_q         <= cnt_d;
			fill_q        <= fill_d;
			sync_q        <= sync_d;
			out_valid_q   <= out_valid_d;
		end
	end

	// color shifter and output payload
	always_ff @(posedge clk) begin
		shift_q <= shift_d;
		if (ld) begin
			o_frame_q <= frame_count_q;
			o_row_q   <= ld_row_sync ? bgfe_pkg::FIRST_ROW : row_q;
			o_col_q   <= ld_col;
			o_white_q <= ld_white;
			o_kind_q  <= ld_kind;
			o_last_q  <= ld_last;
			o_flast_q <= ld_flast;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_index = o_frame_q;
	assign cell_row    = o_row_q;
	assign cell_col    = o_col_q;
	assign cell_white  = o_white_q;
	assign cell_kind   = o_kind_q;
	assign run_last    = o_last_q;
	assign frame_last  = o_flast_q;

	// frame_last only on the closing corner
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> (cell_row == bgfe_pkg::LAST_ROW)
			&& (cell_col == bgfe_pkg::NARROW_END))
		else $error("frame_last away from the closing cell");

	// a sync cell never ends an item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cell_kind == bgfe_pkg::KIND_SYNC) |-> !run_last)
		else $error("run_last on a sync cell");

	// every emitted cell belongs to an opened frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_index != 8'd0))
		else $error("cell emitted with no frame open");

	// an unused opcode leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (opcode == bgfe_pkg::OP_UNUSED) |=> in_ready)
		else $error("unused opcode started a run");

endmodule
